// ===== rtl/acbe_pkg.sv =====
`default_nettype none
package acbe_pkg;

    localparam logic       CMD_LOAD     = 1'b0;
    localparam logic       CMD_PROCESS  = 1'b1;
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;
    localparam logic [3:0] LAST_ROUND   = 4'd10;
    localparam int         RK_ROWS      = 11;
    localparam logic [7:0] GF_POLY      = 8'h1B;
    localparam logic [7:0] RCON_FIRST   = 8'h01;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    typedef enum logic [1:0] {ST_KEXP, ST_IDLE, ST_RUN, ST_FLUSH} t_state;

    typedef struct packed {
        logic        command;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        last_block;
    } t_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        last_out;
    } t_out;

    typedef struct packed {
        logic       kx_first;
        logic       kx_step;
        logic [3:0] kx_addr;
        logic [3:0] rk_addr;
        logic       take_load;
        logic       take_block;
        logic       step;
        logic       step_first;
        logic       step_last;
        logic       flush;
    } t_cmd;

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gmc(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] x2, x4, x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        case (k)
            4'h1:    return a;
            4'h2:    return x2;
            4'h3:    return x2 ^ a;
            4'h9:    return x8 ^ a;
            4'hB:    return x8 ^ x2 ^ a;
            4'hD:    return x8 ^ x4 ^ a;
            4'hE:    return x8 ^ x4 ^ x2;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [127:0] sbox_all(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        end
        return r;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                src = inv ? ((c + 4 - w) & 3) : ((c + w) & 3);
                r[127-8*(c*4+w) -: 8] = s[127-8*(src*4+w) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0]   v;
        logic [3:0]   k;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                v = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    case ((j + 4 - w) & 3)
                        0:       k = inv ? 4'hE : 4'h2;
                        1:       k = inv ? 4'hB : 4'h3;
                        2:       k = inv ? 4'hD : 4'h1;
                        default: k = inv ? 4'h9 : 4'h1;
                    endcase
                    v = v ^ gmc(s[127-8*(c*4+j) -: 8], k);
                end
                r[127-8*(c*4+w) -: 8] = v;
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] next_rk(input logic [127:0] p, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[p[23:16]], SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]} ^ {rc, 24'h0};
        w0 = p[127:96] ^ t;
        w1 = p[95:64] ^ w0;
        w2 = p[63:32] ^ w1;
        w3 = p[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes128_cbc_block_engine.sv =====
// Load beat: accepted while idle, loads the chain value, no result.
// Process beat: after acceptance the block runs 11 round steps, then waits in flush until the output is free;
// no new block is taken until the previous one is flushed, set by the single shared round unit.
// Reset (synchronous, active low) clears chain, keys and mode, then expands the 11 round keys;
// every key register write restarts that expansion before the next beat is taken.
`default_nettype none
module aes128_cbc_block_engine
    import acbe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out        o_out_data,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [63:0]  i_cfg_wdata
);
    logic [63:0] r_key_high, r_key_low;
    logic        r_mode;
    logic        key_wr, out_free;
    t_cmd        cmd;

    assign key_wr = i_cfg_we && (i_cfg_index == REG_KEY_HIGH || i_cfg_index == REG_KEY_LOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                REG_MODE:     r_mode     <= i_cfg_wdata[0];
                default:      r_mode     <= r_mode;
            endcase
        end
    end

    acbe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_wr     (key_wr),
        .i_mode       (r_mode),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .i_out_free   (out_free),
        .o_in_ready   (o_in_ready),
        .o_cmd        (cmd)
    );

    acbe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       ({r_key_high, r_key_low}),
        .i_mode      (r_mode),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ===== rtl/acbe_ram.sv =====
`default_nettype none
module acbe_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/acbe_ctrl.sv =====
`default_nettype none
module acbe_ctrl
    import acbe_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_key_wr,
    input  wire   i_mode,
    input  wire   i_in_valid,
    input  wire   i_in_command,
    input  wire   i_out_free,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] cnt_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KEXP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_KEXP: begin
                if (r_cnt == LAST_ROUND) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && i_in_command == CMD_PROCESS) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST_ROUND) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_FLUSH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_key_wr) begin
            n_state = ST_KEXP;
            n_cnt   = '0;
        end
    end

    assign cnt_nx = (r_cnt == LAST_ROUND) ? LAST_ROUND : r_cnt + 4'd1;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.kx_addr = r_cnt;
        o_cmd.rk_addr = i_mode ? LAST_ROUND - cnt_nx : cnt_nx;
        case (r_state)
            ST_KEXP: begin
                o_cmd.kx_first = (r_cnt == '0);
                o_cmd.kx_step  = (r_cnt != '0);
            end
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.rk_addr    = i_mode ? LAST_ROUND : 4'd0;
                o_cmd.take_load  = i_in_valid && i_in_command == CMD_LOAD;
                o_cmd.take_block = i_in_valid && i_in_command == CMD_PROCESS;
            end
            ST_RUN: begin
                o_cmd.step       = 1'b1;
                o_cmd.step_first = (r_cnt == '0);
                o_cmd.step_last  = (r_cnt == LAST_ROUND);
            end
            ST_FLUSH: begin
                o_cmd.flush = i_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    a_key_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_key_wr |=> r_state == ST_KEXP && r_cnt == '0)
        else $error("key write did not restart expansion");
    a_run_to_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN && r_cnt == LAST_ROUND && !i_key_wr |=> r_state == ST_FLUSH)
        else $error("final round not followed by flush");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_ROUND)
        else $error("round counter out of range");
endmodule
`default_nettype wire

// ===== rtl/acbe_dpath.sv =====
`default_nettype none
module acbe_dpath
    import acbe_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    input  wire [127:0]  i_key,
    input  wire          i_mode,
    input  t_in          i_in_data,
    input  wire          i_out_ready,
    output logic         o_out_free,
    output logic         o_out_valid,
    output t_out         o_out_data
);
    logic [127:0] r_state, r_chain, r_saved, r_prev, r_out;
    logic [7:0]   r_rcon;
    logic         r_last, r_out_last, r_out_valid;
    logic [127:0] rk, kx_data, enc_nx, dec_nx, n_state, din, res;

    acbe_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_rk (
        .i_clk   (i_clk),
        .i_we    (i_cmd.kx_first || i_cmd.kx_step),
        .i_waddr (i_cmd.kx_addr),
        .i_wdata (kx_data),
        .i_raddr (i_cmd.rk_addr),
        .o_rdata (rk)
    );

    assign din     = {i_in_data.data_high, i_in_data.data_low};
    assign kx_data = i_cmd.kx_first ? i_key : next_rk(r_prev, r_rcon);

    always_comb begin
        enc_nx = rotate_rows(sbox_all(r_state, 1'b0), 1'b0);
        if (!i_cmd.step_last) begin
            enc_nx = mix_cols(enc_nx, 1'b0);
        end
        enc_nx = enc_nx ^ rk;
        dec_nx = sbox_all(rotate_rows(r_state, 1'b1), 1'b1) ^ rk;
        if (!i_cmd.step_last) begin
            dec_nx = mix_cols(dec_nx, 1'b1);
        end
        if (i_cmd.step_first) begin
            n_state = r_state ^ rk;
        end else begin
            n_state = i_mode ? dec_nx : enc_nx;
        end
    end

    assign res = i_mode ? (r_state ^ r_chain) : r_state;

    always_ff @(posedge i_clk) begin
        if (i_cmd.kx_first || i_cmd.kx_step) begin
            r_prev <= kx_data;
            r_rcon <= i_cmd.kx_first ? RCON_FIRST : xt(r_rcon);
        end
        if (i_cmd.take_block) begin
            r_state <= i_mode ? din : din ^ r_chain;
            r_saved <= din;
            r_last  <= i_in_data.last_block;
        end else if (i_cmd.step) begin
            r_state <= n_state;
        end
        if (i_cmd.flush) begin
            r_out      <= res;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_load) begin
                r_chain <= din;
            end else if (i_cmd.flush) begin
                r_chain <= i_mode ? r_saved : r_state;
            end
            if (i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = '{result_high: r_out[127:64], result_low: r_out[63:0],
                           last_out: r_out_last};

    a_flush_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !i_cmd.flush)
        else $error("result overwritten while held");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_block |-> !i_cmd.step && !i_cmd.flush && !i_cmd.kx_step)
        else $error("block taken while busy");
    a_flush_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> r_out_valid)
        else $error("flush did not raise result valid");
endmodule
`default_nettype wire
